// ===== design/lfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpc_pkg
// Shared types, register indexes and duty tables of the line follower
// PWM controller.
// ----------------------------------------------------------------------------
package lfpc_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned ProxW    = 16;
  localparam int unsigned PwmCntW  = 8;
  localparam int unsigned BlinkW   = 10;
  localparam int unsigned PosW     = 4;
  localparam int unsigned NumLine  = 5;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SampleW-1:0] ThresholdReset = 10'd300;
  localparam logic [ProxW:0]     ProxMargin     = 17'd50;
  localparam logic [BlinkW-1:0]  BlinkLimit     = 10'd700;
  localparam logic [BlinkW-1:0]  BlinkMax       = 10'd1023;

  typedef enum logic [0:0] {
    CFG_LINE_THRESHOLD = 1'b0,
    CFG_PROX_BASELINE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_INITIAL = 2'd0,
    MODE_CENTRE  = 2'd1,
    MODE_RIGHT   = 2'd2,
    MODE_LEFT    = 2'd3
  } speed_mode_e;

  typedef struct packed {
    logic [SampleW-1:0] sensor_a;
    logic [SampleW-1:0] sensor_b;
    logic [SampleW-1:0] sensor_c;
    logic [SampleW-1:0] sensor_d;
    logic [SampleW-1:0] sensor_e;
    logic               tick;
    logic               prox_valid;
    logic [ProxW-1:0]   prox_value;
  } lfpc_in_t;

  typedef struct packed {
    logic                   left_drive;
    logic                   right_drive;
    logic                   front_light;
    logic                   brake_light;
    logic                   blink_light;
    logic signed [PosW-1:0] line_position;
  } lfpc_out_t;

  typedef struct packed {
    logic [PwmCntW-1:0] on1;
    logic [PwmCntW-1:0] off1;
    logic [PwmCntW-1:0] on2;
    logic [PwmCntW-1:0] off2;
  } duty_t;

  // on/off durations in ticks for both motors; braking overrides the mode
  function automatic duty_t lfpc_duty(speed_mode_e mode, logic brake);
    duty_t d;
    if (brake) begin
      d = '{on1: 8'd2, off1: 8'd80, on2: 8'd2, off2: 8'd80};
    end else begin
      case (mode)
        MODE_INITIAL: d = '{on1: 8'd100, off1: 8'd100, on2: 8'd100, off2: 8'd100};
        MODE_CENTRE:  d = '{on1: 8'd13,  off1: 8'd45,  on2: 8'd13,  off2: 8'd45};
        MODE_RIGHT:   d = '{on1: 8'd18,  off1: 8'd45,  on2: 8'd2,   off2: 8'd60};
        MODE_LEFT:    d = '{on1: 8'd2,   off1: 8'd60,  on2: 8'd18,  off2: 8'd45};
        default:      d = '{on1: 8'd100, off1: 8'd100, on2: 8'd100, off2: 8'd100};
      endcase
    end
    return d;
  endfunction

endpackage

// ===== design/lfpc_in_if.sv =====
// ----------------------------------------------------------------------------
// lfpc_in_if
// Valid/ready channel carrying one control iteration.
// ----------------------------------------------------------------------------
interface lfpc_in_if;
  import lfpc_pkg::*;

  logic     valid;
  logic     ready;
  lfpc_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/lfpc_out_if.sv =====
// ----------------------------------------------------------------------------
// lfpc_out_if
// Valid/ready channel carrying pin levels and line position.
// ----------------------------------------------------------------------------
interface lfpc_out_if;
  import lfpc_pkg::*;

  logic      valid;
  logic      ready;
  lfpc_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/lfpc_pwm.sv =====
// ----------------------------------------------------------------------------
// lfpc_pwm
// One step of a tick-counted software PWM: pin level and count wrap.
// ----------------------------------------------------------------------------
module lfpc_pwm (
  input  logic [lfpc_pkg::PwmCntW-1:0] count_i,
  input  logic [lfpc_pkg::PwmCntW-1:0] on_i,
  input  logic [lfpc_pkg::PwmCntW-1:0] off_i,
  input  logic                         pin_i,
  output logic                         pin_o,
  output logic [lfpc_pkg::PwmCntW-1:0] count_o
);
  import lfpc_pkg::*;

  logic [PwmCntW-1:0] lim;

  // durations stay at or below 100 each, so the sum fits the count width
  assign lim = on_i + off_i;

  always_comb begin
    pin_o = pin_i;
    if (count_i <= on_i) begin
      pin_o = 1'b1;
    end
    // at count == on the low phase wins
    if (count_i >= on_i && count_i <= lim) begin
      pin_o = 1'b0;
    end
    count_o = (count_i >= lim) ? '0 : count_i;
  end
endmodule

// ===== design/lfpc_step.sv =====
// ----------------------------------------------------------------------------
// lfpc_step
// Combinational control iteration: line bits, mode, PWMs, lights, blink.
// ----------------------------------------------------------------------------
module lfpc_step (
  input  lfpc_pkg::lfpc_in_t                 item_i,
  input  logic [lfpc_pkg::SampleW-1:0]       threshold_i,
  input  logic [lfpc_pkg::ProxW-1:0]         baseline_i,
  input  logic [lfpc_pkg::NumLine-1:0]       line_bits_i,
  input  logic signed [lfpc_pkg::PosW-1:0]   pos_i,
  input  lfpc_pkg::speed_mode_e              mode_i,
  input  logic [lfpc_pkg::PwmCntW-1:0]       cnt1_i,
  input  logic [lfpc_pkg::PwmCntW-1:0]       cnt2_i,
  input  logic [lfpc_pkg::BlinkW-1:0]        blink_cnt_i,
  input  logic                               obstacle_i,
  input  lfpc_pkg::lfpc_out_t                pins_i,
  output logic [lfpc_pkg::NumLine-1:0]       line_bits_o,
  output logic signed [lfpc_pkg::PosW-1:0]   pos_o,
  output lfpc_pkg::speed_mode_e              mode_o,
  output logic [lfpc_pkg::PwmCntW-1:0]       cnt1_o,
  output logic [lfpc_pkg::PwmCntW-1:0]       cnt2_o,
  output logic [lfpc_pkg::BlinkW-1:0]        blink_cnt_o,
  output logic                               obstacle_o,
  output lfpc_pkg::lfpc_out_t                pins_o
);
  import lfpc_pkg::*;

  logic [SampleW-1:0] samples [NumLine];
  logic [PwmCntW-1:0] c1, c2;
  logic [BlinkW-1:0]  bc;
  logic [ProxW:0]     prox_lim;
  logic [ProxW:0]     prox_ext;
  duty_t              duty;
  logic               pin_l, pin_r;

  assign samples[0] = item_i.sensor_a;
  assign samples[1] = item_i.sensor_b;
  assign samples[2] = item_i.sensor_c;
  assign samples[3] = item_i.sensor_d;
  assign samples[4] = item_i.sensor_e;

  // equal sample keeps its bit
  always_comb begin
    line_bits_o = line_bits_i;
    for (int i = 0; i < NumLine; i++) begin
      if (samples[i] > threshold_i) begin
        line_bits_o[i] = 1'b1;
      end else if (samples[i] < threshold_i) begin
        line_bits_o[i] = 1'b0;
      end
    end
  end

  always_comb begin
    mode_o = mode_i;
    pos_o  = pos_i;
    case (line_bits_o)
      5'b11111, 5'b00100, 5'b01110: begin mode_o = MODE_CENTRE; pos_o = 4'sd0; end
      5'b00001:           begin mode_o = MODE_RIGHT; pos_o = 4'sd4; end
      5'b00011:           begin mode_o = MODE_RIGHT; pos_o = 4'sd3; end
      5'b00010, 5'b00111: begin mode_o = MODE_RIGHT; pos_o = 4'sd2; end
      5'b00110, 5'b01111: begin mode_o = MODE_RIGHT; pos_o = 4'sd1; end
      5'b10000:           begin mode_o = MODE_LEFT;  pos_o = -4'sd4; end
      5'b11000:           begin mode_o = MODE_LEFT;  pos_o = -4'sd3; end
      5'b01000, 5'b11100: begin mode_o = MODE_LEFT;  pos_o = -4'sd2; end
      5'b01100, 5'b11110: begin mode_o = MODE_LEFT;  pos_o = -4'sd1; end
      5'b00000: begin
        // line lost at an edge: keep turning toward it
        if (pos_i == -4'sd4) begin
          mode_o = MODE_LEFT;
        end else if (pos_i == 4'sd4) begin
          mode_o = MODE_RIGHT;
        end
      end
      default: ;
    endcase
  end

  assign c1 = item_i.tick ? cnt1_i + 8'd1 : cnt1_i;
  assign c2 = item_i.tick ? cnt2_i + 8'd1 : cnt2_i;
  assign bc = (item_i.tick && blink_cnt_i != BlinkMax) ? blink_cnt_i + 10'd1 : blink_cnt_i;

  // braking uses the obstacle flag from before this item's reading
  assign duty = lfpc_duty(mode_o, obstacle_i);

  lfpc_pwm u_pwm_left (
    .count_i (c1),
    .on_i    (duty.on1),
    .off_i   (duty.off1),
    .pin_i   (pins_i.left_drive),
    .pin_o   (pin_l),
    .count_o (cnt1_o)
  );

  lfpc_pwm u_pwm_right (
    .count_i (c2),
    .on_i    (duty.on2),
    .off_i   (duty.off2),
    .pin_i   (pins_i.right_drive),
    .pin_o   (pin_r),
    .count_o (cnt2_o)
  );

  assign prox_lim = {1'b0, baseline_i} + ProxMargin;
  assign prox_ext = {1'b0, item_i.prox_value};

  always_comb begin
    pins_o               = pins_i;
    pins_o.left_drive    = pin_l;
    pins_o.right_drive   = pin_r;
    pins_o.line_position = pos_o;
    obstacle_o           = obstacle_i;
    blink_cnt_o          = bc;
    if (item_i.prox_valid) begin
      obstacle_o = 1'b0;
      if (prox_ext < prox_lim) begin
        pins_o.front_light = 1'b1;
        pins_o.brake_light = 1'b0;
      end
      if (prox_ext > prox_lim) begin
        pins_o.front_light = 1'b0;
        pins_o.brake_light = 1'b1;
        obstacle_o         = 1'b1;
      end
    end
    if (bc > BlinkLimit) begin
      pins_o.blink_light = ~pins_i.blink_light;
      blink_cnt_o        = '0;
    end
  end
endmodule

// ===== design/line_follower_pwm_controller.sv =====
// ----------------------------------------------------------------------------
// line_follower_pwm_controller
// Line follower control iteration with software motor PWMs and lights.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  in_i      in   valid / ready    five line samples, tick, proximity reading
//  out_o     out  valid / ready    motor pins, light pins, line position
//  cfg_*     in   cfg_we_i only    line threshold, proximity baseline
//
//  one transaction per clock while out_o is not stalled; a result reaches
//  out_o through the input register, then the result register
//  controller state advances as the input register hands over to the result
//  register, from one layer of compares and small adders between them
//  rst_ni clears all state but s1_data_q; threshold resets to 300, baseline to 0
//  a stalled out_o holds its result while one more transaction waits in the
//  input register; in_i.ready drops only when both are full
// ----------------------------------------------------------------------------
module line_follower_pwm_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lfpc_in_if.sink                         in_i,
  lfpc_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  lfpc_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [lfpc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import lfpc_pkg::*;

  logic               s1_valid_q;
  lfpc_in_t           s1_data_q;
  logic               out_valid_q, out_valid_d;
  lfpc_out_t          pins_q, pins_d;
  logic               s1_adv;

  logic [SampleW-1:0] threshold_q;
  logic [ProxW-1:0]   baseline_q;

  logic [NumLine-1:0]     line_bits_q, line_bits_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  speed_mode_e            mode_q, mode_d;
  logic [PwmCntW-1:0]     cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [BlinkW-1:0]      blink_cnt_q, blink_cnt_d;
  logic                   obstacle_q, obstacle_d;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign out_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = pins_q;

  lfpc_step u_step (
    .item_i      (s1_data_q),
    .threshold_i (threshold_q),
    .baseline_i  (baseline_q),
    .line_bits_i (line_bits_q),
    .pos_i       (pos_q),
    .mode_i      (mode_q),
    .cnt1_i      (cnt1_q),
    .cnt2_i      (cnt2_q),
    .blink_cnt_i (blink_cnt_q),
    .obstacle_i  (obstacle_q),
    .pins_i      (pins_q),
    .line_bits_o (line_bits_d),
    .pos_o       (pos_d),
    .mode_o      (mode_d),
    .cnt1_o      (cnt1_d),
    .cnt2_o      (cnt2_d),
    .blink_cnt_o (blink_cnt_d),
    .obstacle_o  (obstacle_d),
    .pins_o      (pins_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      baseline_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_THRESHOLD: threshold_q <= cfg_data_i[SampleW-1:0];
        CFG_PROX_BASELINE:  baseline_q  <= cfg_data_i[ProxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_data_q <= in_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pins_q      <= '0;
      line_bits_q <= '0;
      pos_q       <= '0;
      mode_q      <= MODE_INITIAL;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      blink_cnt_q <= '0;
      obstacle_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        pins_q      <= pins_d;
        line_bits_q <= line_bits_d;
        pos_q       <= pos_d;
        mode_q      <= mode_d;
        cnt1_q      <= cnt1_d;
        cnt2_q      <= cnt2_d;
        blink_cnt_q <= blink_cnt_d;
        obstacle_q  <= obstacle_d;
      end
    end
  end

  a_lights_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pins_q.front_light && pins_q.brake_light))
    else $error("front and brake lights both on");

  a_obstacle_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obstacle_q |-> pins_q.brake_light)
    else $error("obstacle flagged without brake light");

  a_pwm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt1_q <= 8'd200 && cnt2_q <= 8'd200)
    else $error("pwm count beyond period");

  a_blink_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_cnt_q <= BlinkLimit)
    else $error("blink count not restarted");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q >= -4'sd4 && pos_q <= 4'sd4)
    else $error("line position out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(cnt1_q) && $stable(blink_cnt_q) && $stable(pins_q))
    else $error("state changed without a transaction");
endmodule
